// File: rtl/core/hse_pkg.sv
// Shared types for the heap sort engine.
// Command and status groups between hse_ctrl and hse_dp; no dependencies.
package hse_pkg;

  localparam int unsigned DATA_W = 32;

  typedef struct packed {
    logic load;
    logic build_init;
    logic build_fetch;
    logic sift_top;
    logic sift_cmp;
    logic sift_put;
    logic ext_init;
    logic ext_rd;
    logic ext_swap;
    logic out_init;
    logic out_rd;
    logic out_cap;
  } cmd_t;

  typedef struct packed {
    logic k_zero;
    logic k_le1;
    logic ext_more;
    logic cmp_stop;
    logic next_leaf;
    logic out_last;
    logic out_fire;
  } stat_t;

endpackage

// File: rtl/core/hse_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module hse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: rtl/core/hse_dp.sv
// Datapath of the heap sort engine: value store, heap indexes, sift compare
// and output register. Depends on hse_pkg and hse_ram.
module hse_dp
  import hse_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic [DATA_W-1:0] in_value_i,
  output logic [DATA_W-1:0] out_value_o,
  output logic              out_valid_o,
  output logic              out_last_o,
  output logic              out_ovf_o,
  input  logic              out_ready_i
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned IW = CW + 2;

  logic [CW-1:0]            cnt_q, cnt_d;
  logic                     ovf_q, ovf_d;
  logic                     out_valid_q, out_valid_d;
  logic [CW-1:0]            k_q, len_q;
  logic [AW-1:0]            p_q, idx_q;
  logic signed [DATA_W-1:0] v_q;
  logic [DATA_W-1:0]        out_value_q;
  logic                     out_last_q, out_ovf_q;

  logic                     we;
  logic [AW-1:0]            waddr, raddr_a, raddr_b;
  logic [DATA_W-1:0]        wdata, rd_a, rd_b;

  logic [CW-1:0]            k_m1;
  logic [IW-1:0]            c_w, c1_w, len_w, child_idx, next_c;
  logic                     full, has_r, pick_r, cmp_stop, out_fire;
  logic signed [DATA_W-1:0] child_val;

  hse_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_ITEMS)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  assign k_m1      = k_q - CW'(1);
  assign c_w       = (IW'(p_q) << 1) + IW'(1);
  assign c1_w      = c_w + IW'(1);
  assign len_w     = IW'(len_q);
  assign full      = (cnt_q == CW'(MAX_ITEMS));
  assign has_r     = (c1_w < len_w);
  assign pick_r    = has_r && ($signed(rd_b) > $signed(rd_a));
  assign child_val = pick_r ? $signed(rd_b) : $signed(rd_a);
  assign child_idx = pick_r ? c1_w : c_w;
  assign next_c    = (child_idx << 1) + IW'(1);
  assign cmp_stop  = (v_q > child_val);
  assign out_fire  = out_valid_q && out_ready_i;

  always_comb begin
    we      = 1'b0;
    waddr   = p_q;
    wdata   = v_q;
    raddr_a = c_w[AW-1:0];
    raddr_b = c1_w[AW-1:0];
    if (cmd_i.load && !full) begin
      we    = 1'b1;
      waddr = cnt_q[AW-1:0];
      wdata = in_value_i;
    end else if (cmd_i.sift_cmp) begin
      we    = 1'b1;
      wdata = cmp_stop ? v_q : child_val;
    end else if (cmd_i.sift_put) begin
      we    = 1'b1;
    end else if (cmd_i.ext_swap) begin
      we    = 1'b1;
      waddr = k_m1[AW-1:0];
      wdata = rd_a;
    end
    if (cmd_i.build_fetch) begin
      raddr_a = k_m1[AW-1:0];
    end else if (cmd_i.ext_rd) begin
      raddr_a = '0;
      raddr_b = k_m1[AW-1:0];
    end else if (cmd_i.out_rd) begin
      raddr_a = idx_q;
    end
  end

  always_comb begin
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    if (cmd_i.load) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CW'(1);
      end
    end
    if (cmd_i.out_cap) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
      if (out_last_q) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.build_init) begin
      k_q   <= cnt_q >> 1;
      len_q <= cnt_q;
    end
    if (cmd_i.build_fetch) begin
      k_q <= k_m1;
      p_q <= k_m1[AW-1:0];
    end
    if (cmd_i.sift_top) begin
      v_q <= $signed(rd_a);
    end
    if (cmd_i.sift_cmp && !cmp_stop) begin
      p_q <= child_idx[AW-1:0];
    end
    if (cmd_i.ext_init) begin
      k_q <= len_q;
    end
    if (cmd_i.ext_swap) begin
      v_q   <= $signed(rd_b);
      p_q   <= '0;
      len_q <= k_m1;
      k_q   <= k_m1;
    end
    if (cmd_i.out_init) begin
      idx_q <= '0;
    end else if (out_fire && !out_last_q) begin
      idx_q <= idx_q + AW'(1);
    end
    if (cmd_i.out_cap) begin
      out_value_q <= rd_a;
      out_last_q  <= ((CW'(idx_q) + CW'(1)) == cnt_q);
      out_ovf_q   <= ovf_q;
    end
  end

  assign stat_o.k_zero    = (k_q == '0);
  assign stat_o.k_le1     = (k_q <= CW'(1));
  assign stat_o.ext_more  = (k_q > CW'(2));
  assign stat_o.cmp_stop  = cmp_stop;
  assign stat_o.next_leaf = (next_c >= len_w);
  assign stat_o.out_last  = out_last_q;
  assign stat_o.out_fire  = out_fire;

  assign out_value_o = out_value_q;
  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_ovf_o   = out_ovf_q;

endmodule

// File: rtl/core/hse_ctrl.sv
// Controller of the heap sort engine: load, heap build, extraction and
// output sequencing. Depends on hse_pkg.
module hse_ctrl
  import hse_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_end_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [13:0] {
    ST_LOAD    = 14'b00000000000001,
    ST_B_INIT  = 14'b00000000000010,
    ST_B_NEXT  = 14'b00000000000100,
    ST_B_FETCH = 14'b00000000001000,
    ST_S_TOP   = 14'b00000000010000,
    ST_S_RD    = 14'b00000000100000,
    ST_S_CMP   = 14'b00000001000000,
    ST_S_PUT   = 14'b00000010000000,
    ST_E_NEXT  = 14'b00000100000000,
    ST_E_RD    = 14'b00001000000000,
    ST_E_SWAP  = 14'b00010000000000,
    ST_O_RD    = 14'b00100000000000,
    ST_O_CAP   = 14'b01000000000000,
    ST_O_WAIT  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   ext_q, ext_d;
  state_e after_sift;

  assign after_sift = ext_q ? ST_E_NEXT : ST_B_NEXT;
  assign in_ready_o = (state_q == ST_LOAD);

  always_comb begin
    state_d = state_q;
    ext_d   = ext_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_end_i) begin
            state_d = ST_B_INIT;
          end
        end
      end
      ST_B_INIT: begin
        cmd_o.build_init = 1'b1;
        ext_d            = 1'b0;
        state_d          = ST_B_NEXT;
      end
      ST_B_NEXT: begin
        if (stat_i.k_zero) begin
          cmd_o.ext_init = 1'b1;
          ext_d          = 1'b1;
          state_d        = ST_E_NEXT;
        end else begin
          state_d = ST_B_FETCH;
        end
      end
      ST_B_FETCH: begin
        cmd_o.build_fetch = 1'b1;
        state_d           = ST_S_TOP;
      end
      ST_S_TOP: begin
        cmd_o.sift_top = 1'b1;
        state_d        = ST_S_CMP;
      end
      ST_S_RD: begin
        state_d = ST_S_CMP;
      end
      ST_S_CMP: begin
        cmd_o.sift_cmp = 1'b1;
        if (stat_i.cmp_stop) begin
          state_d = after_sift;
        end else if (stat_i.next_leaf) begin
          state_d = ST_S_PUT;
        end else begin
          state_d = ST_S_RD;
        end
      end
      ST_S_PUT: begin
        cmd_o.sift_put = 1'b1;
        state_d        = after_sift;
      end
      ST_E_NEXT: begin
        if (stat_i.k_le1) begin
          cmd_o.out_init = 1'b1;
          state_d        = ST_O_RD;
        end else begin
          state_d = ST_E_RD;
        end
      end
      ST_E_RD: begin
        cmd_o.ext_rd = 1'b1;
        state_d      = ST_E_SWAP;
      end
      ST_E_SWAP: begin
        cmd_o.ext_swap = 1'b1;
        state_d        = stat_i.ext_more ? ST_S_RD : ST_S_PUT;
      end
      ST_O_RD: begin
        cmd_o.out_rd = 1'b1;
        state_d      = ST_O_CAP;
      end
      ST_O_CAP: begin
        cmd_o.out_cap = 1'b1;
        state_d       = ST_O_WAIT;
      end
      ST_O_WAIT: begin
        if (stat_i.out_fire) begin
          state_d = stat_i.out_last ? ST_LOAD : ST_O_RD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      ext_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ext_q   <= ext_d;
    end
  end

endmodule

// File: rtl/core/heap_sort_engine_top.sv
// Top level of the heap sort engine: stream ports, controller and datapath.
// Depends on hse_pkg, hse_ctrl and hse_dp.
//
//   channel  | dir | tdata               | tlast        | tuser
//   s_axis   | in  | [31:0] sample_value | end_of_set   | -
//   m_axis   | out | [31:0] sorted_value | final_result | [0] overflowed
//
// Load takes one item per cycle while s_axis_tvalid is high; input is taken
// only while loading. The sort uses one compare unit over a two-read-port
// store; a sift that ends at a leaf writes its value back in a separate put
// step. Output reads, captures and presents one result at a time and reads
// the next only after the previous one is taken; a stall holds the result in
// the output register. Reset clears count, flag and controller.
module heap_sort_engine_top
  import hse_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample_value
  input  logic        s_axis_tlast,   // end_of_set
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
  output logic        m_axis_tlast,   // final_result
  output logic [0:0]  m_axis_tuser    // [0] overflowed
);

  cmd_t  cmd;
  stat_t stat;
  logic  ovf;

  hse_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_end_i  (s_axis_tlast),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  hse_dp #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_value_i (s_axis_tdata),
    .out_value_o(m_axis_tdata),
    .out_valid_o(m_axis_tvalid),
    .out_last_o (m_axis_tlast),
    .out_ovf_o  (ovf),
    .out_ready_i(m_axis_tready)
  );

  assign m_axis_tuser = ovf;

endmodule

// File: rtl/core/hse_checker.sv
// Port-level checks for the heap sort engine, bound to its top level.
// Depends on heap_sort_engine_top.
module hse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [0:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result is pending");

  a_sort_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input still taken after end of set");

  a_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
      s_axis_tready && !m_axis_tvalid)
    else $error("no return to loading after last result");

endmodule

bind heap_sort_engine_top hse_checker u_hse_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser)
);

// File: tb/heap_sort_checker.sv
// Checker for heap_sort_engine_top: watches both stream channels and predicts sorted sets.
// Runs its own heapsort over the accepted values and compares each result item in order.
// Depends on hse_pkg.
`timescale 1ns / 1ps
module heap_sort_checker
  import hse_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_i,
  input  logic [DATA_W-1:0] s_axis_tdata_i,
  input  logic              s_axis_tlast_i,
  input  logic              m_axis_tvalid_i,
  input  logic              m_axis_tready_i,
  input  logic [DATA_W-1:0] m_axis_tdata_i,
  input  logic              m_axis_tlast_i,
  input  logic [0:0]        m_axis_tuser_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       results_o
);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     ovf;
  } sorted_item_t;

  logic signed [DATA_W-1:0] held_vals [MAX_ITEMS];
  int unsigned              held_count;
  logic                     dropped_seen;
  sorted_item_t             sorted_due [$];

  task automatic swap_held(input int unsigned a, input int unsigned b);
    logic signed [DATA_W-1:0] t;
    t = held_vals[a];
    held_vals[a] = held_vals[b];
    held_vals[b] = t;
  endtask

  task automatic heap_settle(input int unsigned root, input int unsigned len);
    int unsigned p;
    int unsigned c;
    p = root;
    c = 2 * p + 1;
    while (c < len) begin
      if (c + 1 < len && held_vals[c + 1] > held_vals[c]) c++;
      if (held_vals[p] > held_vals[c]) break;
      swap_held(p, c);
      p = c;
      c = 2 * c + 1;
    end
  endtask

  task automatic heap_order(input int unsigned n);
    int unsigned k;
    for (k = n / 2; k > 0; k--) heap_settle(k - 1, n);
    for (k = n; k > 1; k--) begin
      swap_held(0, k - 1);
      heap_settle(0, k - 1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_item_t got;
    sorted_item_t want;
    if (!rst_ni) begin
      held_count   = 0;
      dropped_seen = 1'b0;
      sorted_due.delete();
      fail_count_o = 0;
      results_o    = 0;
      pending_o    = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = '{value: m_axis_tdata_i, last: m_axis_tlast_i, ovf: m_axis_tuser_i[0]};
        results_o++;
        if (sorted_due.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result item: value %0d last %0b ovf %0b",
                   $time, got.value, got.last, got.ovf);
        end else begin
          want = sorted_due.pop_front();
          if (got.value !== want.value || got.last !== want.last || got.ovf !== want.ovf) begin
            fail_count_o++;
            $display("%0t: mismatch: expected value %0d last %0b ovf %0b,",
                     $time, want.value, want.last, want.ovf,
                     " got value %0d last %0b ovf %0b",
                     got.value, got.last, got.ovf);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (held_count < MAX_ITEMS) begin
          held_vals[held_count] = s_axis_tdata_i;
          held_count++;
        end else begin
          dropped_seen = 1'b1;
        end
        if (s_axis_tlast_i) begin
          heap_order(held_count);
          for (int unsigned k = 0; k < held_count; k++) begin
            want = '{value: held_vals[k], last: (k + 1 == held_count), ovf: dropped_seen};
            sorted_due = {sorted_due, want};
          end
          held_count   = 0;
          dropped_seen = 1'b0;
        end
      end
      pending_o = sorted_due.size();
    end
  end

endmodule

// File: tb/tb_heap_sort_engine_top.sv
// Testbench top for heap_sort_engine_top: drives value sets and a stalling result consumer.
// Relies on heap_sort_checker for prediction and comparison; depends on hse_pkg.
`timescale 1ns / 1ps
module tb_heap_sort_engine_top
  import hse_pkg::*;
();

  localparam int unsigned MAX_ITEMS   = 32;
  localparam int unsigned ITEM_TARGET = 260;
  localparam int unsigned HOLD_CYCLES = 400;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata;
  logic              s_axis_tlast;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [DATA_W-1:0] m_axis_tdata;
  logic              m_axis_tlast;
  logic [0:0]        m_axis_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned phase;
  int unsigned items_sent;
  int unsigned sets_sent;
  int unsigned overrun_sets;
  logic        long_hold_done;
  logic [DATA_W-1:0] pick [$];

  heap_sort_engine_top #(
    .MAX_ITEMS(MAX_ITEMS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  heap_sort_checker #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tlast_i (s_axis_tlast),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .m_axis_tlast_i (m_axis_tlast),
    .m_axis_tuser_i (m_axis_tuser),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("** heap_sort_engine_top: FAILED **");
    $finish;
  end

  // Consumer: random stalls per phase, one long hold when full rate starts.
  initial begin
    m_axis_tready  = 1'b0;
    long_hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (phase == 2 && !long_hold_done) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        long_hold_done = 1'b1;
      end
      m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_item(input logic [DATA_W-1:0] v, input logic l);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = v;
    s_axis_tlast  = l;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_set();
    for (int unsigned i = 0; i < pick.size(); i++) send_item(pick[i], i + 1 == pick.size());
    sets_sent++;
    if (pick.size() > MAX_ITEMS) overrun_sets++;
  endtask

  function automatic logic [DATA_W-1:0] draw_value();
    int unsigned r;
    logic [1:0]  hi;
    r  = $urandom_range(99);
    hi = $urandom_range(3);
    if (r < 50) return $urandom;
    if (r < 75) return DATA_W'(int'($urandom_range(8)) - 4);
    if (r < 85) return {hi, {(DATA_W - 2){hi[0]}}};
    return {hi, {(DATA_W - 2){1'b0}}};
  endfunction

  function automatic int unsigned draw_length(input int unsigned set_no);
    int unsigned r;
    r = $urandom_range(99);
    if (set_no == 0) return MAX_ITEMS;
    if (set_no == 1) return MAX_ITEMS + 1 + $urandom_range(7);
    if (r < 60) return $urandom_range(8, 1);
    if (r < 80) return $urandom_range(MAX_ITEMS - 1, 9);
    if (r < 90) return MAX_ITEMS;
    return $urandom_range(MAX_ITEMS + 8, MAX_ITEMS + 1);
  endfunction

  initial begin
    int unsigned set_no;
    int unsigned len;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    tx_idle_pct   = 38;
    rx_idle_pct   = 52;
    phase         = 0;
    items_sent    = 0;
    sets_sent     = 0;
    overrun_sets  = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    pick = '{32'h8000_0000};
    send_set();
    pick = '{32'h7FFF_FFFF};
    send_set();
    pick = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
    send_set();
    pick = '{32'd5, 32'd5, 32'd5, 32'd5};
    send_set();
    pick = '{32'hAAAA_AAAA, 32'h5555_5555};
    send_set();
    pick = '{32'd3, 32'd2, 32'd1};
    send_set();

    set_no = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase == 0 && items_sent >= 100) begin
        phase       = 1;
        tx_idle_pct = 52;
        rx_idle_pct = 38;
      end else if (phase == 1 && items_sent >= 180) begin
        phase       = 2;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      len = draw_length(set_no);
      pick.delete();
      repeat (len) pick = {pick, draw_value()};
      send_set();
      set_no++;
    end
    s_axis_tvalid = 1'b0;
    s_axis_tlast  = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);

    $display("Sent %0d values in %0d sets (%0d overran the %0d-entry store);",
             items_sent, sets_sent, overrun_sets, MAX_ITEMS,
             " checked %0d results.", results);
    $display("Stalls swapped between sender and consumer, then a %0d-cycle hold %s",
             HOLD_CYCLES, "of the output at full rate.");
    if (fail_count == 0) begin
      $display("** heap_sort_engine_top: PASSED **");
    end else begin
      $display("** heap_sort_engine_top: FAILED **");
    end
    $finish;
  end

endmodule
